// ===== rtl/aree_pkg.sv =====
// ----------------------------------------------------------------------------
// aree_pkg
// Shared constants for the audio region edit engine: sample width, default
// sizes, register indexes, request kinds, edit mode codes, reset values and the normalize target.
// ----------------------------------------------------------------------------
package aree_pkg;

  // Sample width of the stream fields
  localparam int SAMPLE_BITS = 24;

  // Default region size
  localparam int DEF_MAX_FRAMES   = 8192;
  localparam int DEF_MAX_CHANNELS = 8;

  // Configuration register indexes
  localparam logic [1:0] REG_EDIT_MODE = 2'd0;
  localparam logic [1:0] REG_GAIN      = 2'd1;
  localparam logic [1:0] REG_CHANNELS  = 2'd2;

  // Request kinds
  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_FETCH = 1'b1;

  // Edit mode codes
  localparam logic [2:0] MODE_MUTE      = 3'd0;
  localparam logic [2:0] MODE_NORMALIZE = 3'd1;
  localparam logic [2:0] MODE_FADE_IN   = 3'd2;
  localparam logic [2:0] MODE_FADE_OUT  = 3'd3;
  localparam logic [2:0] MODE_REVERSE   = 3'd4;
  localparam logic [2:0] MODE_GAIN      = 3'd5;

  // Reset values of the registers
  localparam logic [2:0]  RST_EDIT_MODE = MODE_GAIN;
  localparam logic [15:0] UNITY_GAIN    = 16'd16384;
  localparam logic [3:0]  RST_CHANNELS  = 4'd2;

  // Half scale and 0.99 of full scale, rounded
  localparam longint SHALF       = longint'(1) << (SAMPLE_BITS - 1);
  localparam longint NORM_TARGET = (99 * SHALF + 50) / 100;

endpackage

// ===== rtl/audio_region_edit_engine_top.sv =====
// ----------------------------------------------------------------------------
// audio_region_edit_engine_top
// Stores a region of interleaved samples, then returns it processed by
// mute, normalize, fade in, fade out, per-channel reverse or fixed gain.
// ----------------------------------------------------------------------------
// Flow: a load is taken in the idle state. A scaling fetch makes two divider
// passes, first for the frame count, then for the rounded scaled sample; mute,
// reverse and pass-through skip the second pass, and a refused fetch answers
// after the first. Throughput: one item at a time; the input waits until the
// pending result has been taken.
// Reset is synchronous: mode 5, unity gain, two channels, empty open region.
module audio_region_edit_engine_top
  import aree_pkg::*;
#(
  parameter int MAX_FRAMES   = DEF_MAX_FRAMES,
  parameter int MAX_CHANNELS = DEF_MAX_CHANNELS
) (
  input  logic                   clk,
  input  logic                   rst,
  // Input stream
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [SAMPLE_BITS-1:0] s_axis_tdata,  // [23:0] sample_in
  input  logic                   s_axis_tuser,  // [0] req_type
  input  logic                   s_axis_tlast,  // load_last
  // Output stream
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [SAMPLE_BITS-1:0] m_axis_tdata,  // [23:0] sample_out
  output logic                   m_axis_tuser,  // [0] fetch_status
  output logic                   m_axis_tlast,  // region_end
  // Configuration
  input  logic                   cfg_we,
  input  logic [1:0]             cfg_index,
  input  logic [15:0]            cfg_data
);

  localparam int SB    = SAMPLE_BITS;
  localparam int DEPTH = MAX_FRAMES * MAX_CHANNELS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LW    = $clog2(DEPTH + 1);
  localparam int FW    = $clog2(MAX_FRAMES + 1);
  localparam int CCW   = $clog2(MAX_CHANNELS + 1);
  localparam int CHW   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int VW    = (SB > FW) ? SB : FW;
  localparam int NW    = SB + VW + 2;
  localparam int DVW   = VW + 2;
  localparam int CNTW  = $clog2(NW + 1);

  // Sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_FDIV = 3'd1;
  localparam logic [2:0] S_POS  = 3'd2;
  localparam logic [2:0] S_RD   = 3'd3;
  localparam logic [2:0] S_MUL  = 3'd4;
  localparam logic [2:0] S_LDIV = 3'd5;
  localparam logic [2:0] S_SDIV = 3'd6;
  localparam logic [2:0] S_OUT  = 3'd7;

  // Configuration registers
  logic [2:0]  edit_mode;
  logic [15:0] gain_factor;
  logic [3:0]  channel_count;

  // Region state
  logic [LW-1:0]  samples_loaded;
  logic [SB-1:0]  peak_magnitude;
  logic [FW-1:0]  fetch_frame;
  logic [CHW-1:0] fetch_channel;
  logic           region_closed;
  logic [SB-1:0]  normalize_scale;

  // Sequencer and work registers
  logic [2:0]     state;
  logic [CCW-1:0] chans;
  logic [FW-1:0]  frames;
  logic [FW-1:0]  cur_frame;
  logic [CHW-1:0] cur_chan;
  logic [AW-1:0]  raddr;
  logic [SB-1:0]  rd_data;
  logic           neg;
  logic [SB+VW-1:0] prod;
  logic [VW-1:0]  den;
  logic [SB-1:0]  res;

  // Shared divider registers
  logic [NW-1:0]   dq;
  logic [DVW-1:0]  dr;
  logic [DVW-1:0]  dd;
  logic [CNTW-1:0] dcnt;

  // Sample memory
  logic [SB-1:0] mem [DEPTH];

  // ---- Live channel count, clamped to the supported range
  logic [CCW-1:0] c_live;
  always_comb begin
    if (channel_count == 4'd0) begin
      c_live = CCW'(1);
    end else if (32'(channel_count) > MAX_CHANNELS) begin
      c_live = CCW'(MAX_CHANNELS);
    end else begin
      c_live = CCW'(channel_count);
    end
  end

  // ---- Handshake
  logic in_xfer;
  assign s_axis_tready = (state == S_IDLE) && !m_axis_tvalid;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  // ---- Load path: new region base values and peak update
  logic [LW-1:0] base_cnt;
  logic [SB-1:0] base_peak;
  logic [SB-1:0] in_mag;
  logic          store_ok;
  logic [SB-1:0] peak_new;
  logic          mem_we;
  always_comb begin
    base_cnt  = region_closed ? '0 : samples_loaded;
    base_peak = region_closed ? '0 : peak_magnitude;
    in_mag    = s_axis_tdata[SB-1] ? (~s_axis_tdata + 1'b1) : s_axis_tdata;
    store_ok  = (32'(base_cnt) < DEPTH);
    peak_new  = base_peak;
    if (store_ok && (in_mag > base_peak)) begin
      peak_new = in_mag;
    end
    mem_we = in_xfer && (s_axis_tuser == REQ_LOAD) && store_ok;
  end

  // ---- Shared divider step: one quotient bit a cycle
  logic [DVW-1:0] rs;
  logic           ge;
  always_comb begin
    rs = {dr[DVW-2:0], dq[NW-1]};
    ge = (rs >= dd);
  end

  // ---- Fetch position after a channel count change
  logic [CHW-1:0] ch_adj;
  logic [FW-1:0]  fr_adj;
  logic           fetch_bad;
  always_comb begin
    ch_adj = fetch_channel;
    fr_adj = fetch_frame;
    if (CCW'(fetch_channel) >= c_live) begin
      ch_adj = '0;
      if (fetch_frame < frames) begin
        fr_adj = fetch_frame + 1'b1;
      end
    end
    fetch_bad = !region_closed || (fr_adj >= frames);
  end

  // ---- Source address of the sample to fetch
  logic [FW-1:0]     src;
  logic [FW+CCW-1:0] addr_full;
  always_comb begin
    src       = (edit_mode == MODE_REVERSE) ? (frames - 1'b1 - fr_adj) : fr_adj;
    addr_full = src * c_live + (FW + CCW)'(ch_adj);
  end

  // ---- Scale operands for the fetched sample
  logic [SB-1:0] x_mag;
  logic [VW-1:0] num_sel;
  logic [VW-1:0] den_sel;
  logic          do_scale;
  logic          do_zero;
  always_comb begin
    x_mag    = rd_data[SB-1] ? (~rd_data + 1'b1) : rd_data;
    num_sel  = '0;
    den_sel  = VW'(1);
    do_scale = 1'b0;
    do_zero  = 1'b0;
    unique case (edit_mode)
      MODE_MUTE: begin
        do_zero = 1'b1;
      end
      MODE_NORMALIZE: begin
        do_scale = (normalize_scale != '0);
        num_sel  = VW'(NORM_TARGET);
        den_sel  = VW'(normalize_scale);
      end
      MODE_FADE_IN: begin
        do_scale = 1'b1;
        num_sel  = VW'(cur_frame);
        den_sel  = VW'(frames);
      end
      MODE_FADE_OUT: begin
        do_scale = 1'b1;
        num_sel  = VW'(frames - cur_frame);
        den_sel  = VW'(frames);
      end
      MODE_GAIN: begin
        do_scale = 1'b1;
        num_sel  = VW'(gain_factor);
        den_sel  = VW'(UNITY_GAIN);
      end
      default: begin
        do_scale = 1'b0;
      end
    endcase
  end

  // ---- Rounded quotient, saturated and signed
  logic [SB-1:0] sat_res;
  always_comb begin
    if (neg) begin
      if (dq > NW'(SHALF)) begin
        sat_res = SB'(SHALF);
      end else begin
        sat_res = SB'(dq);
      end
      sat_res = ~sat_res + 1'b1;
    end else begin
      if (dq > NW'(SHALF - 1)) begin
        sat_res = SB'(SHALF - 1);
      end else begin
        sat_res = SB'(dq);
      end
    end
  end

  // ---- Sample memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[base_cnt[AW-1:0]] <= s_axis_tdata;
    end
    rd_data <= mem[raddr];
  end

  // ---- Configuration, region state and sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      edit_mode       <= RST_EDIT_MODE;
      gain_factor     <= UNITY_GAIN;
      channel_count   <= RST_CHANNELS;
      samples_loaded  <= '0;
      peak_magnitude  <= '0;
      fetch_frame     <= '0;
      fetch_channel   <= '0;
      region_closed   <= 1'b0;
      normalize_scale <= '0;
      state           <= S_IDLE;
      m_axis_tvalid   <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_EDIT_MODE: edit_mode     <= cfg_data[2:0];
          REG_GAIN:      gain_factor   <= cfg_data;
          REG_CHANNELS:  channel_count <= cfg_data[3:0];
          default:       ;
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_xfer) begin
            if (s_axis_tuser == REQ_LOAD) begin
              // Load: a closed region restarts, then the sample is stored
              samples_loaded <= store_ok ? base_cnt + 1'b1 : base_cnt;
              peak_magnitude <= peak_new;
              if (region_closed || s_axis_tlast) begin
                fetch_frame   <= '0;
                fetch_channel <= '0;
              end
              region_closed   <= s_axis_tlast;
              normalize_scale <= s_axis_tlast ? peak_new : '0;
            end else begin
              // Fetch: first the whole frame count
              chans <= c_live;
              dq    <= NW'(samples_loaded);
              dr    <= '0;
              dd    <= DVW'(c_live);
              dcnt  <= CNTW'(NW);
              state <= S_FDIV;
            end
          end
        end
        S_FDIV: begin
          if (dcnt != '0) begin
            dr   <= ge ? rs - dd : rs;
            dq   <= {dq[NW-2:0], ge};
            dcnt <= dcnt - 1'b1;
          end else begin
            frames <= (dq > NW'(MAX_FRAMES)) ? FW'(MAX_FRAMES) : FW'(dq);
            state  <= S_POS;
          end
        end
        S_POS: begin
          fetch_channel <= ch_adj;
          fetch_frame   <= fr_adj;
          if (fetch_bad) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= '0;
            m_axis_tlast  <= 1'b0;
            m_axis_tuser  <= 1'b1;
            state         <= S_IDLE;
          end else begin
            cur_frame <= fr_adj;
            cur_chan  <= ch_adj;
            raddr     <= AW'(addr_full);
            state     <= S_RD;
          end
        end
        S_RD: begin
          state <= S_MUL;
        end
        S_MUL: begin
          neg  <= rd_data[SB-1];
          prod <= x_mag * num_sel;
          den  <= den_sel;
          if (do_zero) begin
            res   <= '0;
            state <= S_OUT;
          end else if (!do_scale) begin
            res   <= rd_data;
            state <= S_OUT;
          end else begin
            state <= S_LDIV;
          end
        end
        S_LDIV: begin
          // Round to nearest: (2*mag*num + den) / (2*den)
          dq    <= {1'b0, prod, 1'b0} + NW'(den);
          dr    <= '0;
          dd    <= {1'b0, den, 1'b0};
          dcnt  <= CNTW'(NW);
          state <= S_SDIV;
        end
        S_SDIV: begin
          if (dcnt != '0) begin
            dr   <= ge ? rs - dd : rs;
            dq   <= {dq[NW-2:0], ge};
            dcnt <= dcnt - 1'b1;
          end else begin
            res   <= sat_res;
            state <= S_OUT;
          end
        end
        S_OUT: begin
          m_axis_tvalid <= 1'b1;
          m_axis_tdata  <= res;
          m_axis_tlast  <= (cur_frame == frames - 1'b1) &&
                           (CCW'(cur_chan) == chans - 1'b1);
          m_axis_tuser  <= 1'b0;
          if (CCW'(cur_chan) + 1'b1 >= chans) begin
            fetch_channel <= '0;
            fetch_frame   <= cur_frame + 1'b1;
          end else begin
            fetch_channel <= cur_chan + 1'b1;
          end
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
